/* rtl/core/rgb_luma_histogram_defines.svh */
// Assertion macros shared by the histogram checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RGB_LUMA_HISTOGRAM_DEFINES_SVH
`define RGB_LUMA_HISTOGRAM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rlh_pkg.sv */
// Shared constants and types for the RGB and luma histogram block.
// No dependencies; rlh_luma, rlh_bins, the top level and the checker use this package.
`default_nettype none

package rlh_pkg;

  localparam int BIN_COUNT_DEF  = 256;
  localparam int COUNT_BITS_DEF = 24;
  localparam int NUM_STORES     = 4;

  localparam int OP_BITS    = 2;
  localparam int COMP_BITS  = 8;
  localparam int CHAN_BITS  = 2;
  localparam int INDEX_BITS = 8;
  localparam int OUT_BITS   = 24;
  localparam int STEP_BITS  = 6;

  localparam logic [OP_BITS-1:0] OP_PIXEL = 2'd0;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_BITS-1:0] OP_READ  = 2'd2;

  // Store order, which is also the channel code of a read.
  localparam int STORE_RED   = 0;
  localparam int STORE_GREEN = 1;
  localparam int STORE_BLUE  = 2;
  localparam int STORE_LUMA  = 3;

  localparam logic [STEP_BITS-1:0] STEP_RESET = 6'd1;

  // BT.709 luma weights in Q16; they sum to 65536, so the luma fits in 8 bits.
  localparam int LUMA_BITS = 24;
  localparam logic [15:0] LUMA_KR = 16'd13933;
  localparam logic [15:0] LUMA_KG = 16'd46871;
  localparam logic [15:0] LUMA_KB = 16'd4732;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } rlh_bins_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/rlh_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module rlh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rlh_luma.sv */
// BT.709 luma from 8-bit red, green and blue: registered products, then sum.
// Depends on rlh_pkg.
`default_nettype none

module rlh_luma (
  input  logic                          clk,
  input  logic [rlh_pkg::COMP_BITS-1:0] red,
  input  logic [rlh_pkg::COMP_BITS-1:0] green,
  input  logic [rlh_pkg::COMP_BITS-1:0] blue,
  output logic [rlh_pkg::COMP_BITS-1:0] luma
);

  import rlh_pkg::*;

  logic [LUMA_BITS-1:0] prod_r;
  logic [LUMA_BITS-1:0] prod_g;
  logic [LUMA_BITS-1:0] prod_b;
  logic [LUMA_BITS-1:0] sum;

  always_ff @(posedge clk) begin
    prod_r <= LUMA_BITS'(LUMA_KR) * LUMA_BITS'(red);
    prod_g <= LUMA_BITS'(LUMA_KG) * LUMA_BITS'(green);
    prod_b <= LUMA_BITS'(LUMA_KB) * LUMA_BITS'(blue);
  end

  // The weights sum to one in Q16, so the sum never exceeds 24 bits.
  assign sum  = prod_r + prod_g + prod_b;
  assign luma = sum[LUMA_BITS-1:LUMA_BITS-COMP_BITS];

endmodule

`default_nettype wire

/* rtl/core/rlh_bins.sv */
// The four bin stores: one RAM each, a wiping pass after reset and on every clear,
// and the saturating increment written back after a read. Depends on rlh_pkg, rlh_ram.
`default_nettype none

module rlh_bins #(
  parameter int BIN_COUNT  = rlh_pkg::BIN_COUNT_DEF,
  parameter int COUNT_BITS = rlh_pkg::COUNT_BITS_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  rlh_pkg::rlh_bins_ctrl_t                              ctrl,
  input  logic [rlh_pkg::NUM_STORES-1:0][$clog2(BIN_COUNT)-1:0] addr,
  output logic                                                 busy,
  output logic [rlh_pkg::NUM_STORES-1:0][COUNT_BITS-1:0]        count,
  output logic [rlh_pkg::NUM_STORES-1:0][COUNT_BITS-1:0]        count_inc
);

  import rlh_pkg::*;

  localparam int ADDR_BITS = $clog2(BIN_COUNT);

  logic [NUM_STORES-1:0][ADDR_BITS-1:0]  addr_q;
  logic [NUM_STORES-1:0][COUNT_BITS-1:0] rd_data;
  logic                                  clearing;
  logic [ADDR_BITS-1:0]                  clr_addr;
  logic                                  ram_wr_en;

  // Reset and every clear start a pass that writes zero to one entry of each
  // store per cycle, through all BIN_COUNT entries.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_BITS'(BIN_COUNT - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      for (int s = 0; s < NUM_STORES; s++) begin
        addr_q[s] <= addr[s];
      end
    end
  end

  assign busy      = clearing;
  assign ram_wr_en = ctrl.wr_en || clearing;

  for (genvar s = 0; s < NUM_STORES; s++) begin : g_store
    rlh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BIN_COUNT)
    ) u_ram (
      .clk     (clk),
      .wr_en   (ram_wr_en),
      .wr_addr (clearing ? clr_addr : addr_q[s]),
      .wr_data (clearing ? '0 : count_inc[s]),
      .rd_en   (ctrl.rd_en),
      .rd_addr (addr[s]),
      .rd_data (rd_data[s])
    );

    assign count[s]     = rd_data[s];
    assign count_inc[s] = (count[s] == {COUNT_BITS{1'b1}}) ? count[s]
                                                           : count[s] + COUNT_BITS'(1);
  end

endmodule

`default_nettype wire

/* rtl/core/rgb_luma_histogram.sv */
// RGB and BT.709 luma histogram, top level.
// Depends on rlh_pkg, rlh_luma, rlh_bins (and through it rlh_ram).
//
// Items arrive on the item channel (item_valid / item_stall); one transfer is
// taken at a rising edge with item_valid high and item_stall low. A pixel that
// falls on the subsample grid holds the input through the transfer, the luma
// products, the store read, the write-back of the incremented bins and the peak
// update; a pixel off the grid only advances the phases. A clear holds the
// input while the four RAMs are wiped one entry per cycle. A read passes a
// request and a response state, then loads the output register and frees the
// input together once that register is free; the result is held there until
// the result channel (result_valid / result_stall) completes the transfer. The
// rate is set by the read-modify-write of the bin RAMs: one item is in work at
// a time. A new item is taken while a result waits; a second read then waits
// for the output register to empty. The sample_step register is written over
// the cfg channel (cfg_valid / cfg_ready) only while the block is idle, and a
// pending write holds the item channel. Synchronous reset sets the peak to
// one, the phases to zero and the step to one, then runs the same wiping pass
// before the first item is taken; no transfer is taken while rst is high.
`default_nettype none

module rgb_luma_histogram #(
  parameter int BIN_COUNT  = rlh_pkg::BIN_COUNT_DEF,
  parameter int COUNT_BITS = rlh_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rlh_pkg::STEP_BITS-1:0]  cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [rlh_pkg::OP_BITS-1:0]    operation,
  input  logic [rlh_pkg::COMP_BITS-1:0]  red,
  input  logic [rlh_pkg::COMP_BITS-1:0]  green,
  input  logic [rlh_pkg::COMP_BITS-1:0]  blue,
  input  logic                           last_in_line,
  input  logic [rlh_pkg::CHAN_BITS-1:0]  channel,
  input  logic [rlh_pkg::INDEX_BITS-1:0] bin_index,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [rlh_pkg::OUT_BITS-1:0]   bin_count,
  output logic [rlh_pkg::OUT_BITS-1:0]   peak_count
);

  import rlh_pkg::*;

  localparam int ADDR_BITS = $clog2(BIN_COUNT);
  localparam int EXT_BITS  = OUT_BITS + COUNT_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LUMA   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_UPD    = 3'd3;
  localparam logic [2:0] S_PEAK   = 3'd4;
  localparam logic [2:0] S_RDREQ  = 3'd5;
  localparam logic [2:0] S_RDRESP = 3'd6;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [STEP_BITS-1:0]   sample_step;
  logic [STEP_BITS-1:0]   column_phase;
  logic [STEP_BITS-1:0]   row_phase;
  logic [COUNT_BITS-1:0]  peak;
  logic [COUNT_BITS-1:0]  max_lo;
  logic [COUNT_BITS-1:0]  max_hi;
  logic [COUNT_BITS-1:0]  max_all;
  logic [COMP_BITS-1:0]   red_q;
  logic [COMP_BITS-1:0]   green_q;
  logic [COMP_BITS-1:0]   blue_q;
  logic [CHAN_BITS-1:0]   channel_q;
  logic [INDEX_BITS-1:0]  index_q;
  logic [COMP_BITS-1:0]   luma;
  logic                   item_take;
  logic                   on_grid;
  logic                   out_free;
  logic                   bins_busy;
  logic [EXT_BITS-1:0]    bin_ext;
  logic [EXT_BITS-1:0]    peak_ext;
  rlh_bins_ctrl_t         ctrl;
  logic [NUM_STORES-1:0][ADDR_BITS-1:0]  addr;
  logic [NUM_STORES-1:0][COUNT_BITS-1:0] count;
  logic [NUM_STORES-1:0][COUNT_BITS-1:0] count_inc;

  function automatic logic [STEP_BITS-1:0] phase_advance(
    input logic [STEP_BITS-1:0] phase,
    input logic [STEP_BITS-1:0] step
  );
    logic [STEP_BITS:0]   bumped;
    logic [STEP_BITS-1:0] eff;
    bumped = {1'b0, phase} + (STEP_BITS + 1)'(1);
    // A step of zero behaves as a step of one.
    eff    = (step == '0) ? STEP_BITS'(1) : step;
    return (bumped >= {1'b0, eff}) ? '0 : bumped[STEP_BITS-1:0];
  endfunction

  assign cfg_ready  = !rst && (state == S_IDLE) && !bins_busy;
  // A pending register write goes first, so the step never changes under an item.
  assign item_stall = rst || (state != S_IDLE) || bins_busy || cfg_valid;
  assign item_take  = item_valid && !item_stall;
  assign on_grid    = (column_phase == '0) && (row_phase == '0);
  assign out_free   = !result_valid || !result_stall;
  assign max_all    = (max_hi > max_lo) ? max_hi : max_lo;

  always_comb begin
    state_next = state;
    ctrl       = '0;
    for (int s = 0; s < NUM_STORES; s++) begin
      addr[s] = index_q[ADDR_BITS-1:0];
    end
    case (state)
      S_IDLE: begin
        if (item_take) begin
          case (operation)
            OP_PIXEL: begin
              if (on_grid) begin
                state_next = S_LUMA;
              end
            end
            OP_CLEAR: ctrl.clear = 1'b1;
            OP_READ:  state_next = S_RDREQ;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_LUMA: state_next = S_READ;
      S_READ: begin
        ctrl.rd_en            = 1'b1;
        addr[STORE_RED]   = red_q[ADDR_BITS-1:0];
        addr[STORE_GREEN] = green_q[ADDR_BITS-1:0];
        addr[STORE_BLUE]  = blue_q[ADDR_BITS-1:0];
        addr[STORE_LUMA]  = luma[ADDR_BITS-1:0];
        state_next            = S_UPD;
      end
      S_UPD: begin
        ctrl.wr_en = 1'b1;
        state_next = S_PEAK;
      end
      S_PEAK: state_next = S_IDLE;
      S_RDREQ: begin
        ctrl.rd_en = 1'b1;
        state_next = S_RDRESP;
      end
      S_RDRESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_step  <= STEP_RESET;
      column_phase <= '0;
      row_phase    <= '0;
      peak         <= COUNT_BITS'(1);
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        sample_step <= cfg_data;
      end
      if (state == S_RDRESP && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (item_take) begin
        case (operation)
          OP_PIXEL: begin
            if (last_in_line) begin
              column_phase <= '0;
              row_phase    <= phase_advance(row_phase, sample_step);
            end else begin
              column_phase <= phase_advance(column_phase, sample_step);
            end
          end
          OP_CLEAR: begin
            column_phase <= '0;
            row_phase    <= '0;
            peak         <= COUNT_BITS'(1);
          end
          default: begin
          end
        endcase
      end
      if (state == S_PEAK && max_all > peak) begin
        peak <= max_all;
      end
    end
  end

  // Payload registers; they need no reset.
  always_ff @(posedge clk) begin
    if (item_take) begin
      red_q     <= red;
      green_q   <= green;
      blue_q    <= blue;
      channel_q <= channel;
      index_q   <= bin_index;
    end
    if (state == S_UPD) begin
      max_lo <= (count_inc[STORE_GREEN] > count_inc[STORE_RED]) ? count_inc[STORE_GREEN]
                                                                 : count_inc[STORE_RED];
      max_hi <= (count_inc[STORE_LUMA] > count_inc[STORE_BLUE]) ? count_inc[STORE_LUMA]
                                                                : count_inc[STORE_BLUE];
    end
    if (state == S_RDRESP && out_free) begin
      bin_count  <= bin_ext[OUT_BITS-1:0];
      peak_count <= peak_ext[OUT_BITS-1:0];
    end
  end

  // Counts wider than the output are cut to its width; narrower ones are padded.
  assign bin_ext  = {{OUT_BITS{1'b0}}, count[channel_q]};
  assign peak_ext = {{OUT_BITS{1'b0}}, peak};

  rlh_luma u_luma (
    .clk   (clk),
    .red   (red_q),
    .green (green_q),
    .blue  (blue_q),
    .luma  (luma)
  );

  rlh_bins #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_bins (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .addr      (addr),
    .busy      (bins_busy),
    .count     (count),
    .count_inc (count_inc)
  );

endmodule

`default_nettype wire

/* rtl/core/rlh_checker.sv */
// Port-level checker for the histogram block, bound to the top level.
// Depends on rlh_pkg and rgb_luma_histogram_defines.svh.
`default_nettype none

`include "rgb_luma_histogram_defines.svh"

module rlh_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic                           item_stall,
  input  logic [rlh_pkg::OP_BITS-1:0]    operation,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  logic [rlh_pkg::OUT_BITS-1:0]   bin_count,
  input  logic [rlh_pkg::OUT_BITS-1:0]   peak_count
);

  import rlh_pkg::*;

  // The peak covers every bin, so no bin read back may exceed it.
  `RLH_ASSERT_SAME(a_bin_within_peak, result_valid, bin_count <= peak_count, "bin count above peak")

  // A read keeps the block busy in the cycle after its transfer.
  `RLH_ASSERT_NEXT(a_read_holds_input, item_valid && !item_stall && operation == OP_READ, item_stall, "read did not hold the input")

  // A clear holds the input while the stores are wiped.
  `RLH_ASSERT_NEXT(a_clear_holds_input, item_valid && !item_stall && operation == OP_CLEAR, item_stall, "clear did not hold the input")

  `RLH_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(bin_count) && $stable(peak_count), "stalled result changed")

endmodule

bind rgb_luma_histogram rlh_checker u_checker (.*);

`default_nettype wire
